// ===== rtl/core/srs_pkg.sv =====
// shared types and constants of the stripe request splitter
`timescale 1ns / 1ps

package srs_pkg;

    // field widths
    localparam int START_W   = 48;
    localparam int LEN_W     = 16;
    localparam int KIB_W     = 11;
    localparam int SWIDTH_W  = 5;
    localparam int OBJ_W     = 39;
    localparam int OFF_W     = 20;
    localparam int BUF_W     = 15;
    localparam int SRV_W     = 4;

    // one KiB is a shift by ten
    localparam int KIB_SHIFT = 10;
    localparam int KIB_MAX   = 1024;
    localparam int SSIZE_W   = KIB_W + KIB_SHIFT;
    localparam int REM_W     = KIB_SHIFT;
    localparam int QUOT_W    = START_W - KIB_SHIFT;
    localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

    // defaults of the top level parameters
    localparam int DEF_MAX_SERVERS = 16;
    localparam int DEF_MAX_LENGTH  = 32768;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_KIB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_WIDTH = 2'd1;
    localparam logic [KIB_W-1:0]     KIB_RESET        = 11'd128;
    localparam logic [SWIDTH_W-1:0]  SWIDTH_RESET     = 5'd1;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request after clamping, with the stripe settings it was issued under
    typedef struct packed {
        logic [START_W-1:0]  start_offset;
        logic [LEN_W-1:0]    length;
        logic [KIB_W-1:0]    kib;
        logic [SWIDTH_W-1:0] swidth;
    } t_srs_job;

    // divider results
    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quotient;
        logic [REM_W-1:0]    remainder;
        logic [SWIDTH_W-1:0] server;
    } t_div_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

endpackage

// ===== rtl/core/srs_if.sv =====
// handshake channels of the stripe request splitter
`timescale 1ns / 1ps

interface srs_req_if;
    logic                        valid;
    logic                        ready;
    logic [srs_pkg::START_W-1:0] start_offset;
    logic [srs_pkg::LEN_W-1:0]   length;

    modport source (output valid, start_offset, length, input ready);
    modport sink   (input valid, start_offset, length, output ready);
endinterface

interface srs_piece_if;
    logic                      valid;
    logic                      ready;
    logic [srs_pkg::OBJ_W-1:0] obj_index;
    logic [srs_pkg::OFF_W-1:0] obj_offset;
    logic [srs_pkg::LEN_W-1:0] piece_length;
    logic [srs_pkg::BUF_W-1:0] buffer_offset;
    logic [srs_pkg::SRV_W-1:0] server_index;
    logic                      last;

    modport source (output valid, obj_index, obj_offset, piece_length,
                    buffer_offset, server_index, last, input ready);
    modport sink   (input valid, obj_index, obj_offset, piece_length,
                    buffer_offset, server_index, last, output ready);
endinterface

interface srs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [srs_pkg::CFG_IDX_W-1:0]  index;
    logic [srs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/srs_front.sv =====
// front: configuration registers, request clamping and queue push
`timescale 1ns / 1ps

module srs_front #(
    parameter int MAX_SERVERS = srs_pkg::DEF_MAX_SERVERS,
    parameter int MAX_LENGTH  = srs_pkg::DEF_MAX_LENGTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srs_cfg_if.sink           i_cfg,
    srs_req_if.sink           i_req,
    input  logic              i_queue_full,
    output logic              o_push,
    output srs_pkg::t_srs_job o_job
);

    logic [srs_pkg::KIB_W-1:0]    r_kib;
    logic [srs_pkg::SWIDTH_W-1:0] r_swidth;
    logic [srs_pkg::KIB_W-1:0]    kib_eff;
    logic [srs_pkg::SWIDTH_W-1:0] swidth_eff;
    logic [srs_pkg::LEN_W-1:0]    len_eff;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kib    <= srs_pkg::KIB_RESET;
            r_swidth <= srs_pkg::SWIDTH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                srs_pkg::CFG_STRIPE_KIB:   r_kib    <= i_cfg.data[srs_pkg::KIB_W-1:0];
                srs_pkg::CFG_STRIPE_WIDTH: r_swidth <= i_cfg.data[srs_pkg::SWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // zero and oversized settings are pulled into range; oversized lengths are clamped
    always_comb begin
        if (r_kib == '0) begin
            kib_eff = srs_pkg::KIB_W'(1);
        end else if (32'(r_kib) > srs_pkg::KIB_MAX) begin
            kib_eff = srs_pkg::KIB_W'(srs_pkg::KIB_MAX);
        end else begin
            kib_eff = r_kib;
        end

        if (r_swidth == '0) begin
            swidth_eff = srs_pkg::SWIDTH_W'(1);
        end else if (32'(r_swidth) > MAX_SERVERS) begin
            swidth_eff = srs_pkg::SWIDTH_W'(MAX_SERVERS);
        end else begin
            swidth_eff = r_swidth;
        end

        if (32'(i_req.length) > MAX_LENGTH) begin
            len_eff = srs_pkg::LEN_W'(MAX_LENGTH);
        end else begin
            len_eff = i_req.length;
        end
    end

    // zero-length items are taken and dropped
    assign i_req.ready        = !i_queue_full;
    assign o_push             = i_req.valid && !i_queue_full && (i_req.length != '0);
    assign o_job.start_offset = i_req.start_offset;
    assign o_job.length       = len_eff;
    assign o_job.kib          = kib_eff;
    assign o_job.swidth       = swidth_eff;

endmodule

// ===== rtl/core/srs_queue.sv =====
// small request queue between front and back
`timescale 1ns / 1ps

module srs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srs_pkg::t_srs_job i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output srs_pkg::t_srs_job o_job
);

    localparam int DEPTH = srs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srs_pkg::t_srs_job r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (32'(r_count) == DEPTH);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/srs_div.sv =====
// bit-serial divider: offset in KiB by stripe KiB, quotient modulo stripe width
`timescale 1ns / 1ps

module srs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [srs_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [srs_pkg::KIB_W-1:0]    i_divisor,
    input  logic [srs_pkg::SWIDTH_W-1:0] i_swidth,
    output srs_pkg::t_div_result         o_result
);

    logic                         r_busy;
    logic                         r_done;
    logic [srs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [srs_pkg::QUOT_W-1:0]   r_shift;
    logic [srs_pkg::REM_W-1:0]    r_rem;
    logic [srs_pkg::SWIDTH_W-1:0] r_srv;
    logic [srs_pkg::KIB_W-1:0]    r_divisor;
    logic [srs_pkg::SWIDTH_W-1:0] r_swidth;

    logic [srs_pkg::REM_W:0]      rem_trial;
    logic                         qbit;
    logic [srs_pkg::REM_W:0]      rem_next;
    logic [srs_pkg::SWIDTH_W:0]   srv_trial;
    logic [srs_pkg::SWIDTH_W:0]   srv_next;

    // one quotient bit per cycle, msb first; the server remainder follows it
    always_comb begin
        rem_trial = {r_rem, r_shift[srs_pkg::QUOT_W-1]};
        qbit      = (rem_trial >= r_divisor);
        rem_next  = qbit ? rem_trial - r_divisor : rem_trial;
        srv_trial = {r_srv, qbit};
        srv_next  = (srv_trial >= {1'b0, r_swidth}) ? srv_trial - {1'b0, r_swidth}
                                                    : srv_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= srs_pkg::DIV_CNT_W'(srs_pkg::QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == srs_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_shift   <= i_dividend;
            r_rem     <= '0;
            r_srv     <= '0;
            r_divisor <= i_divisor;
            r_swidth  <= i_swidth;
        end else if (r_busy) begin
            r_shift <= {r_shift[srs_pkg::QUOT_W-2:0], qbit};
            r_rem   <= rem_next[srs_pkg::REM_W-1:0];
            r_srv   <= srv_next[srs_pkg::SWIDTH_W-1:0];
        end
    end

    assign o_result.done      = r_done;
    assign o_result.quotient  = r_shift;
    assign o_result.remainder = r_rem;
    assign o_result.server    = r_srv;

endmodule

// ===== rtl/core/srs_back.sv =====
// back: divides one request, then emits its pieces one a cycle while the output is not stalled
`timescale 1ns / 1ps

module srs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  srs_pkg::t_srs_job i_job,
    output logic              o_pop,
    srs_piece_if.source       o_piece
);

    srs_pkg::t_back_state         r_state, n_state;
    srs_pkg::t_div_result         div_res;

    logic [srs_pkg::KIB_SHIFT-1:0] r_start_lo, n_start_lo;
    logic [srs_pkg::KIB_W-1:0]    r_kib, n_kib;
    logic [srs_pkg::SWIDTH_W-1:0] r_swidth, n_swidth;
    logic [srs_pkg::OBJ_W-1:0]    r_obj, n_obj;
    logic [srs_pkg::OFF_W-1:0]    r_off, n_off;
    logic [srs_pkg::LEN_W-1:0]    r_rem_len, n_rem_len;
    logic [srs_pkg::LEN_W-1:0]    r_buf, n_buf;
    logic [srs_pkg::SWIDTH_W-1:0] r_srv, n_srv;

    logic                         r_out_valid, n_out_valid;
    logic [srs_pkg::OBJ_W-1:0]    r_out_obj, n_out_obj;
    logic [srs_pkg::OFF_W-1:0]    r_out_off, n_out_off;
    logic [srs_pkg::LEN_W-1:0]    r_out_len, n_out_len;
    logic [srs_pkg::BUF_W-1:0]    r_out_buf, n_out_buf;
    logic [srs_pkg::SRV_W-1:0]    r_out_srv, n_out_srv;
    logic                         r_out_last, n_out_last;

    logic                         out_free;
    logic [srs_pkg::SSIZE_W-1:0]  ssize;
    logic [srs_pkg::SSIZE_W-1:0]  avail;
    logic                         is_last;
    logic [srs_pkg::LEN_W-1:0]    plen;
    logic [srs_pkg::SWIDTH_W-1:0] srv_inc;

    srs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (o_pop),
        .i_dividend (i_job.start_offset[srs_pkg::START_W-1:srs_pkg::KIB_SHIFT]),
        .i_divisor  (i_job.kib),
        .i_swidth   (i_job.swidth),
        .o_result   (div_res)
    );

    assign out_free = !r_out_valid || o_piece.ready;
    assign ssize    = {r_kib, {srs_pkg::KIB_SHIFT{1'b0}}};
    assign avail    = ssize - {1'b0, r_off};
    assign is_last  = ({{(srs_pkg::SSIZE_W-srs_pkg::LEN_W){1'b0}}, r_rem_len} <= avail);
    assign plen     = is_last ? r_rem_len : avail[srs_pkg::LEN_W-1:0];
    assign srv_inc  = r_srv + 1'b1;

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        n_start_lo  = r_start_lo;
        n_kib       = r_kib;
        n_swidth    = r_swidth;
        n_obj       = r_obj;
        n_off       = r_off;
        n_rem_len   = r_rem_len;
        n_buf       = r_buf;
        n_srv       = r_srv;
        n_out_valid = r_out_valid && !o_piece.ready;
        n_out_obj   = r_out_obj;
        n_out_off   = r_out_off;
        n_out_len   = r_out_len;
        n_out_buf   = r_out_buf;
        n_out_srv   = r_out_srv;
        n_out_last  = r_out_last;

        case (r_state)
            srs_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop      = 1'b1;
                    n_start_lo = i_job.start_offset[srs_pkg::KIB_SHIFT-1:0];
                    n_kib      = i_job.kib;
                    n_swidth   = i_job.swidth;
                    n_rem_len  = i_job.length;
                    n_buf      = '0;
                    n_state    = srs_pkg::ST_DIV;
                end
            end
            srs_pkg::ST_DIV: begin
                if (div_res.done) begin
                    n_obj   = {1'b0, div_res.quotient};
                    n_off   = {div_res.remainder, r_start_lo};
                    n_srv   = div_res.server;
                    n_state = srs_pkg::ST_EMIT;
                end
            end
            srs_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_obj   = r_obj;
                    n_out_off   = r_off;
                    n_out_len   = plen;
                    n_out_buf   = r_buf[srs_pkg::BUF_W-1:0];
                    n_out_srv   = r_srv[srs_pkg::SRV_W-1:0];
                    n_out_last  = is_last;
                    // next piece opens the following object
                    n_obj       = r_obj + 1'b1;
                    n_off       = '0;
                    n_rem_len   = r_rem_len - plen;
                    n_buf       = r_buf + plen;
                    n_srv       = (srv_inc == r_swidth) ? '0 : srv_inc;
                    if (is_last) begin
                        n_state = srs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = srs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_lo <= n_start_lo;
        r_kib      <= n_kib;
        r_swidth   <= n_swidth;
        r_obj      <= n_obj;
        r_off      <= n_off;
        r_rem_len  <= n_rem_len;
        r_buf      <= n_buf;
        r_srv      <= n_srv;
        r_out_obj  <= n_out_obj;
        r_out_off  <= n_out_off;
        r_out_len  <= n_out_len;
        r_out_buf  <= n_out_buf;
        r_out_srv  <= n_out_srv;
        r_out_last <= n_out_last;
    end

    assign o_piece.valid         = r_out_valid;
    assign o_piece.obj_index     = r_out_obj;
    assign o_piece.obj_offset    = r_out_off;
    assign o_piece.piece_length  = r_out_len;
    assign o_piece.buffer_offset = r_out_buf;
    assign o_piece.server_index  = r_out_srv;
    assign o_piece.last          = r_out_last;

endmodule

// ===== rtl/core/stripe_request_splitter_top.sv =====
// top level of the stripe request splitter
// the back divides each item's offset in KiB by the stripe KiB in a 38-step serial divider
// and takes no new item until all pieces of the current one are emitted;
// pieces of one item then leave one a cycle through the output register
// while the output is not stalled
// reset: synchronous, active low; stripe 128 KiB, width 1, queue and pipeline empty
`timescale 1ns / 1ps

module stripe_request_splitter_top #(
    parameter int MAX_SERVERS = srs_pkg::DEF_MAX_SERVERS,
    parameter int MAX_LENGTH  = srs_pkg::DEF_MAX_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srs_cfg_if.sink     i_cfg,
    srs_req_if.sink     i_req,
    srs_piece_if.source o_piece
);

    // front to queue
    logic              push;
    logic              queue_full;
    srs_pkg::t_srs_job push_job;

    // queue to back
    logic              job_valid;
    logic              pop;
    srs_pkg::t_srs_job head_job;

    // front: holds the stripe settings, clamps length and settings,
    // drops zero-length items, tags each request with the settings in force
    srs_front #(
        .MAX_SERVERS (MAX_SERVERS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // short queue so the front keeps taking items while the back divides
    srs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    // back: one division per request for object number, offset and server,
    // then walks the objects with an increment and a wrapping server count
    srs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_piece     (o_piece)
    );

endmodule
